// ----- rtl/sapl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapl_pkg
// Shared types and fixed constants of the servo angle position loop.
// ----------------------------------------------------------------------------
package sapl_pkg;

  localparam int ANGLE_W = 8;
  localparam int POT_W   = 10;
  localparam int REF_W   = 10;
  // widest multiplier power operand: 99^3 fits in 20 bits
  localparam int POW_W   = 20;
  // integer bits of the signed curve accumulator
  localparam int ACC_INT = 14;
  // integer bits of the multiplied coefficients (largest is about 41.2)
  localparam int COEF_INT = 7;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] LIN_MAX   = 8'd60;
  localparam logic [ANGLE_W-1:0] CUB_MAX   = 8'd99;
  localparam logic [REF_W-1:0]   REF_MAX   = 10'd1023;
  localparam logic [REF_W-1:0]   RESET_REF = 10'd960;

  typedef enum logic [1:0] {
    CURVE_LIN,
    CURVE_CUB,
    CURVE_QUA,
    CURVE_HOLD
  } sapl_curve_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_CUBE,
    OP_LIN,
    OP_CUB1,
    OP_CUB2,
    OP_CUB3,
    OP_QUA1,
    OP_QUA2,
    OP_ROUND,
    OP_EMIT
  } sapl_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SQ,
    S_CUBE,
    S_CUB1,
    S_CUB2,
    S_CUB3,
    S_LIN,
    S_QUA1,
    S_QUA2,
    S_ROUND,
    S_EMIT
  } sapl_state_t;

  typedef struct packed {
    sapl_curve_t curve;
    logic        out_free;
  } sapl_status_t;

endpackage

// ----- rtl/sapl_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapl_in_if
// Request channel: requested angle and potentiometer sample.
// ----------------------------------------------------------------------------
interface sapl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] target_angle;
  logic [9:0] pot_sample;

  modport source (output valid, output target_angle, output pot_sample, input ready);
  modport sink (input valid, input target_angle, input pot_sample, output ready);
endinterface

// ----- rtl/sapl_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapl_out_if
// Result channel: direction, PWM duty and reference in use.
// ----------------------------------------------------------------------------
interface sapl_out_if;
  logic       valid;
  logic       ready;
  logic       direction;
  logic [9:0] pwm_duty;
  logic [9:0] reference;

  modport source (output valid, output direction, output pwm_duty, output reference,
                  input ready);
  modport sink (input valid, input direction, input pwm_duty, input reference,
                output ready);
endinterface

// ----- rtl/servo_angle_position_loop.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_angle_position_loop
// Maps a requested angle to a position reference and compares it with the
// potentiometer sample to give direction and PWM duty.
// ----------------------------------------------------------------------------
// Channels: req carries target_angle and pot_sample, rsp carries direction,
// pwm_duty and reference; each transfer completes on valid and ready high.
// One request is worked on at a time. A sequencer drives a single shared
// multiply-accumulate unit: the linear curve takes one multiply, the
// quadratic three, the cubic five; a rounding step then sets the reference.
// Angles 0..60 use the linear curve, 61..99 the cubic, 100..180 the
// quadratic; above 180 the reference is held. req is ready again in the
// cycle rsp valid rises.
// The result sits in an output register. When the receiver stalls, a
// finished result waits there and the next request is still worked up to
// the point of loading the output register, where the sequencer waits.
// Reset (rst, synchronous) empties the output register, returns the
// sequencer to idle and sets the reference to 960, the value for 170 deg.
// ----------------------------------------------------------------------------
module servo_angle_position_loop
  import sapl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  sapl_in_if.sink  req,
  sapl_out_if.source rsp
);

  sapl_op_t     op;
  sapl_status_t status;

  sapl_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .op        (op)
  );

  sapl_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .target_angle  (req.target_angle),
    .pot_sample    (req.pot_sample),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_direction (rsp.direction),
    .out_pwm_duty  (rsp.pwm_duty),
    .out_reference (rsp.reference)
  );

endmodule

// ----- rtl/sapl_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapl_datapath
// Operand registers, shared multiply-accumulate unit, rounding, reference
// register and the output register.
// ----------------------------------------------------------------------------
module sapl_datapath
  import sapl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  sapl_op_t           op,
  output sapl_status_t       status,
  input  logic [ANGLE_W-1:0] target_angle,
  input  logic [POT_W-1:0]   pot_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_direction,
  output logic [POT_W-1:0]   out_pwm_duty,
  output logic [REF_W-1:0]   out_reference
);

  localparam int CW = FRAC_BITS + COEF_INT;
  localparam int AW = FRAC_BITS + ACC_INT;
  localparam int PW = CW + POW_W;
  localparam longint SCALE = longint'(1) << FRAC_BITS;

  // coefficients rounded to nearest, ties up
  localparam longint K_LIN_SLOPE = (68858 * SCALE + 5000) / 10000;
  localparam longint K_LIN_OFFS  = (51515 * SCALE + 500) / 1000;
  localparam longint K_CUB_A3    = (19 * SCALE + 5000) / 10000;
  localparam longint K_CUB_A2    = (4852 * SCALE + 5000) / 10000;
  localparam longint K_CUB_A1    = (41224 * SCALE + 500) / 1000;
  localparam longint K_CUB_A0    = (68149 * SCALE + 50) / 100;
  localparam longint K_QUA_A2    = (372 * SCALE + 5000) / 10000;
  localparam longint K_QUA_A1    = (16419 * SCALE + 500) / 1000;
  localparam longint K_QUA_A0    = (75586 * SCALE + 50) / 100;

  localparam logic [CW-1:0] C_LIN_SLOPE = CW'(K_LIN_SLOPE);
  localparam logic [CW-1:0] C_CUB_A3    = CW'(K_CUB_A3);
  localparam logic [CW-1:0] C_CUB_A2    = CW'(K_CUB_A2);
  localparam logic [CW-1:0] C_CUB_A1    = CW'(K_CUB_A1);
  localparam logic [CW-1:0] C_QUA_A2    = CW'(K_QUA_A2);
  localparam logic [CW-1:0] C_QUA_A1    = CW'(K_QUA_A1);
  localparam logic signed [AW-1:0] C_LIN_OFFS = AW'(K_LIN_OFFS);
  localparam logic signed [AW-1:0] C_CUB_A0   = AW'(K_CUB_A0);
  localparam logic signed [AW-1:0] C_QUA_A0   = AW'(K_QUA_A0);
  localparam logic signed [AW-1:0] HALF = AW'(SCALE / 2);

  logic [ANGLE_W-1:0]     angle;
  logic [POT_W-1:0]       pot;
  logic [2*ANGLE_W-1:0]   sq;
  logic [POW_W-1:0]       cube;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   acc_next;
  logic [REF_W-1:0]       ref_q;
  logic [REF_W-1:0]       ref_round;

  logic [CW-1:0]          mul_a;
  logic [POW_W-1:0]       mul_b;
  logic [PW-1:0]          prod;
  logic signed [AW-1:0]   term;
  logic signed [AW-1:0]   rsum;
  logic [AW-FRAC_BITS-1:0] rint;

  always_comb begin
    if (angle > ANGLE_MAX) begin
      status.curve = CURVE_HOLD;
    end else if (angle <= LIN_MAX) begin
      status.curve = CURVE_LIN;
    end else if (angle <= CUB_MAX) begin
      status.curve = CURVE_CUB;
    end else begin
      status.curve = CURVE_QUA;
    end
    status.out_free = !out_valid || out_ready;
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = CW'(angle);
    mul_b = POW_W'(angle);
    case (op)
      OP_CUBE: mul_a = CW'(sq);
      OP_LIN:  mul_a = C_LIN_SLOPE;
      OP_CUB1: mul_a = C_CUB_A1;
      OP_CUB2: begin
        mul_a = C_CUB_A2;
        mul_b = POW_W'(sq);
      end
      OP_CUB3: begin
        mul_a = C_CUB_A3;
        mul_b = cube;
      end
      OP_QUA1: mul_a = C_QUA_A1;
      OP_QUA2: begin
        mul_a = C_QUA_A2;
        mul_b = POW_W'(sq);
      end
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);
  // every product stays below 2^(13+FRAC_BITS), so it fits the accumulator
  assign term = $signed(AW'(prod));

  always_comb begin
    case (op)
      OP_LIN:  acc_next = term + C_LIN_OFFS;
      OP_CUB1: acc_next = term - C_CUB_A0;
      OP_CUB2: acc_next = acc - term;
      OP_CUB3: acc_next = acc + term;
      OP_QUA1: acc_next = term - C_QUA_A0;
      OP_QUA2: acc_next = acc - term;
      default: acc_next = acc;
    endcase
  end

  // round half up, clamp to 0..1023
  assign rsum = acc + HALF;
  assign rint = rsum[AW-1:FRAC_BITS];
  always_comb begin
    if (acc < 0) begin
      ref_round = '0;
    end else if (rint > (AW-FRAC_BITS)'(REF_MAX)) begin
      ref_round = REF_MAX;
    end else begin
      ref_round = rint[REF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      angle <= target_angle;
      pot   <= pot_sample;
    end
    if (op == OP_SQ) begin
      sq <= prod[2*ANGLE_W-1:0];
    end
    if (op == OP_CUBE) begin
      cube <= prod[POW_W-1:0];
    end
    acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_q <= RESET_REF;
    end else if (op == OP_ROUND) begin
      ref_q <= ref_round;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // below reference: 1023 - (ref - pot) equals pot + ~ref in 10 bits
  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_reference <= ref_q;
      out_direction <= (pot < ref_q);
      out_pwm_duty  <= (pot < ref_q) ? pot + ~ref_q : pot - ref_q;
    end
  end

endmodule

// ----- rtl/sapl_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapl_controller
// Sequencer that steps the datapath through the curve for one request.
// ----------------------------------------------------------------------------
module sapl_controller
  import sapl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  sapl_status_t status,
  output sapl_op_t     op
);

  sapl_state_t state;
  sapl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op         = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.curve)
          CURVE_LIN:  state_next = S_LIN;
          CURVE_HOLD: state_next = S_EMIT;
          default:    state_next = S_SQ;
        endcase
      end
      S_SQ: begin
        op         = OP_SQ;
        state_next = (status.curve == CURVE_CUB) ? S_CUBE : S_QUA1;
      end
      S_CUBE: begin
        op         = OP_CUBE;
        state_next = S_CUB1;
      end
      S_CUB1: begin
        op         = OP_CUB1;
        state_next = S_CUB2;
      end
      S_CUB2: begin
        op         = OP_CUB2;
        state_next = S_CUB3;
      end
      S_CUB3: begin
        op         = OP_CUB3;
        state_next = S_ROUND;
      end
      S_LIN: begin
        op         = OP_LIN;
        state_next = S_ROUND;
      end
      S_QUA1: begin
        op         = OP_QUA1;
        state_next = S_QUA2;
      end
      S_QUA2: begin
        op         = OP_QUA2;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        op         = OP_ROUND;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // wait until the output register can take the result
        if (status.out_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/sapl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapl_checker
// Port-level checks of the servo angle position loop, bound to the top.
// ----------------------------------------------------------------------------
module sapl_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       direction,
  input logic [9:0] pwm_duty,
  input logic [9:0] reference
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(direction) && $stable(pwm_duty) && $stable(reference))
    else $error("rsp payload changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  // one request in flight: no back-to-back transfers
  a_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req taken while busy");

  // duty range follows from direction: at most 1023-ref above, at least below
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (direction ? (pwm_duty >= ~reference) : (pwm_duty <= ~reference)))
    else $error("duty inconsistent with direction and reference");

endmodule

bind servo_angle_position_loop sapl_checker u_sapl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .direction (rsp.direction),
  .pwm_duty  (rsp.pwm_duty),
  .reference (rsp.reference)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks servo_angle_position_loop on its own: a fixed-point copy of the
// angle-to-reference curves predicts direction, duty and reference for every
// request transfer. Directed corners are followed by random requests, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench
  import sapl_pkg::*;
();

  localparam int FRAC_BITS = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_CMDS = 1150;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [POT_W-1:0]   pot;
  } servo_cmd_t;

  typedef struct packed {
    logic             dir;
    logic [POT_W-1:0] duty;
    logic [REF_W-1:0] pos_ref;
  } servo_drive_t;

  function automatic longint q_coef(input longint num, input longint den);
    return ((num <<< FRAC_BITS) + den / 2) / den;
  endfunction

  localparam longint K_LIN_SLOPE = q_coef(68858, 10000);
  localparam longint K_LIN_OFFS  = q_coef(51515, 1000);
  localparam longint K_CUB_A3    = q_coef(19, 10000);
  localparam longint K_CUB_A2    = q_coef(4852, 10000);
  localparam longint K_CUB_A1    = q_coef(41224, 1000);
  localparam longint K_CUB_A0    = q_coef(68149, 100);
  localparam longint K_QUA_A2    = q_coef(372, 10000);
  localparam longint K_QUA_A1    = q_coef(16419, 1000);
  localparam longint K_QUA_A0    = q_coef(75586, 100);

  logic clk;
  logic rst;

  sapl_in_if  req_ch();
  sapl_out_if rsp_ch();

  servo_angle_position_loop #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  servo_cmd_t   cmd_queue[$];
  servo_drive_t drive_due[$];

  logic [REF_W-1:0] tracked_ref;  // predictor copy of the position reference
  logic [REF_W-1:0] plan_ref;     // reference as the stimulus generator sees it
  logic             in_xfer;
  logic             out_xfer;
  logic             src_calm;
  logic             snk_calm;
  int               src_gap;
  int               snk_stall;
  int               idle_cycles;
  int               mismatch_count;
  int               curve_hits[4];
  int               below_count;
  int               above_count;

  logic [ANGLE_W-1:0] corner_angles[8] = '{8'd0, 8'd60, 8'd61, 8'd99, 8'd100, 8'd180,
                                           8'd181, 8'd255};

  function automatic sapl_curve_t curve_of(input logic [ANGLE_W-1:0] angle);
    if (angle > ANGLE_MAX) return CURVE_HOLD;
    if (angle <= LIN_MAX) return CURVE_LIN;
    if (angle <= CUB_MAX) return CURVE_CUB;
    return CURVE_QUA;
  endfunction

  // Curve value in Q.FRAC_BITS, rounded half up, clamped to the 10-bit range.
  function automatic logic [REF_W-1:0] servo_curve(input logic [ANGLE_W-1:0] angle);
    longint a;
    longint v;
    longint r;
    a = longint'(angle);
    case (curve_of(angle))
      CURVE_LIN: v = K_LIN_SLOPE * a + K_LIN_OFFS;
      CURVE_CUB: v = K_CUB_A3 * a * a * a - K_CUB_A2 * a * a + K_CUB_A1 * a - K_CUB_A0;
      default:   v = K_QUA_A1 * a - K_QUA_A2 * a * a - K_QUA_A0;
    endcase
    if (v < 0) return '0;
    r = (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > longint'(REF_MAX)) return REF_MAX;
    return r[REF_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Work out the drive for one accepted request and queue it.
  task automatic track_loop(input servo_cmd_t cmd);
    servo_drive_t d;
    sapl_curve_t  c;
    c = curve_of(cmd.angle);
    curve_hits[c]++;
    if (c != CURVE_HOLD) tracked_ref = servo_curve(cmd.angle);
    d.pos_ref = tracked_ref;
    if (cmd.pot >= tracked_ref) begin
      d.dir  = 1'b0;
      d.duty = cmd.pot - tracked_ref;
      above_count++;
    end else begin
      d.dir  = 1'b1;
      d.duty = REF_MAX - (tracked_ref - cmd.pot);
      below_count++;
    end
    drive_due.push_back(d);
  endtask

  task automatic check_field(input string name, input logic [9:0] want,
                             input logic [9:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic queue_cmd(input logic [ANGLE_W-1:0] angle, input int pot);
    servo_cmd_t c;
    c.angle = angle;
    c.pot   = pot[POT_W-1:0];
    cmd_queue.push_back(c);
    if (curve_of(angle) != CURVE_HOLD) plan_ref = servo_curve(angle);
  endtask

  // Pot sample placed relative to the reference this angle will leave in use.
  task automatic queue_aimed(input logic [ANGLE_W-1:0] angle, input int delta);
    int target;
    target = (curve_of(angle) == CURVE_HOLD) ? int'(plan_ref) : int'(servo_curve(angle));
    target = target + delta;
    if (target < 0) target = 0;
    if (target > int'(REF_MAX)) target = int'(REF_MAX);
    queue_cmd(angle, target);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Request driver: payload changes on the falling edge only.
  always @(negedge clk) begin
    servo_cmd_t c;
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_gap      <= 0;
      src_calm     <= 1'b0;
    end else if (!req_ch.valid || in_xfer) begin
      if (src_gap == 0 && cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.target_angle <= c.angle;
        req_ch.pot_sample   <= c.pot;
        src_gap             <= src_calm ? 0 : pick_gap();
        if ($urandom_range(0, 63) == 0) src_calm <= ~src_calm;
      end else begin
        req_ch.valid        <= 1'b0;
        req_ch.target_angle <= ANGLE_W'($urandom);
        req_ch.pot_sample   <= POT_W'($urandom);
        if (src_gap > 0) src_gap <= src_gap - 1;
      end
    end
  end

  // Result receiver: may stall after a transfer and now and then while idle.
  always @(negedge clk) begin
    int n;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      snk_stall    <= 0;
      snk_calm     <= 1'b0;
    end else begin
      n = snk_stall;
      if (out_xfer || (n == 0 && !snk_calm && $urandom_range(0, 31) == 0))
        n = snk_calm ? 0 : pick_gap();
      if (out_xfer && $urandom_range(0, 47) == 0) snk_calm <= ~snk_calm;
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        snk_stall    <= n - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        snk_stall    <= 0;
      end
    end
  end

  // Predictor and result check on the rising edge.
  always @(posedge clk) begin
    servo_cmd_t   c;
    servo_drive_t want;
    if (rst) begin
      in_xfer     <= 1'b0;
      out_xfer    <= 1'b0;
      idle_cycles <= 0;
      tracked_ref = RESET_REF;
    end else begin
      in_xfer  <= req_ch.valid && req_ch.ready;
      out_xfer <= rsp_ch.valid && rsp_ch.ready;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (req_ch.valid && req_ch.ready) begin
        c.angle = req_ch.target_angle;
        c.pot   = req_ch.pot_sample;
        track_loop(c);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (drive_due.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got dir=%0b duty=%0d ref=%0d",
                   $time, rsp_ch.direction, rsp_ch.pwm_duty, rsp_ch.reference);
          mismatch_count++;
        end else begin
          want = drive_due.pop_front();
          check_field("direction", {9'd0, want.dir}, {9'd0, rsp_ch.direction});
          check_field("pwm_duty", want.duty, rsp_ch.pwm_duty);
          check_field("reference", want.pos_ref, rsp_ch.reference);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r;
    int p;
    logic [ANGLE_W-1:0] angle;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.target_angle = '0;
    req_ch.pot_sample   = '0;
    rsp_ch.ready        = 1'b0;
    idle_cycles         = 0;
    mismatch_count      = 0;
    below_count         = 0;
    above_count         = 0;
    foreach (curve_hits[i]) curve_hits[i] = 0;
    plan_ref            = RESET_REF;

    // directed: holds from reset, segment boundaries, pot extremes and ties
    queue_cmd(8'd200, 0);
    queue_cmd(8'd255, 1023);
    queue_aimed(8'd181, 0);
    queue_cmd(8'd0, 0);
    queue_cmd(8'd0, 1023);
    queue_aimed(8'd60, 0);
    queue_aimed(8'd60, -1);
    queue_aimed(8'd61, 1);
    queue_aimed(8'd61, 0);
    queue_aimed(8'd99, -1);
    queue_aimed(8'd99, 0);
    queue_aimed(8'd100, 0);
    queue_aimed(8'd100, 1);
    queue_cmd(8'd180, 0);
    queue_cmd(8'd180, 1023);
    queue_aimed(8'd180, -1);
    queue_aimed(8'd170, 0);
    queue_aimed(8'd254, -5);
    queue_cmd(8'd128, 512);
    queue_cmd(8'd85, 341);
    queue_cmd(8'd30, 682);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) angle = corner_angles[$urandom_range(0, 7)];
      else if (r < 28) angle = ANGLE_W'($urandom_range(181, 255));
      else angle = ANGLE_W'($urandom_range(0, 180));
      p = $urandom_range(0, 99);
      if (p < 35) queue_cmd(angle, $urandom_range(0, 1023));
      else if (p < 75) queue_aimed(angle, int'($urandom_range(0, 8)) - 4);
      else if (p < 85) queue_cmd(angle, 0);
      else if (p < 95) queue_cmd(angle, 1023);
      else queue_aimed(angle, 0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmd_queue.size() != 0 || req_ch.valid || drive_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (drive_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, drive_due.size());
      mismatch_count++;
    end
    $display("Requests: %0d line, %0d cubic, %0d quadratic, %0d held above 180 deg",
             curve_hits[CURVE_LIN], curve_hits[CURVE_CUB], curve_hits[CURVE_QUA],
             curve_hits[CURVE_HOLD]);
    $display("Pot below reference in %0d, at or above in %0d; %0d mismatches",
             below_count, above_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
